>>> rtl/bpr_pkg.sv
// Shared constants, types and register codes for the bisection root finder.
// Used by bpr_cfg, bpr_horner and bisection_polynomial_root; no dependencies.
`default_nettype none

package bpr_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_COEF  = 6;
  localparam int unsigned MAX_STEPS = 100;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned TOL_W     = 31;
  localparam int unsigned MAG_W     = 47;

  // Largest magnitude the Horner accumulator may hold.
  localparam logic [MAG_W-1:0] ACC_LIMIT = '1;

  // Result codes.
  localparam logic [1:0] OUT_CONV   = 2'd0;
  localparam logic [1:0] OUT_NOSIGN = 2'd1;
  localparam logic [1:0] OUT_LIMIT  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_COEF_LAST = 3'd5;
  localparam logic [2:0] REG_TOL       = 3'd6;

  typedef logic [NUM_COEF-1:0][31:0] coef_arr_t;

  localparam coef_arr_t COEF_RST = {
    32'sd43123, -32'sd568852, 32'sd2726298, -32'sd5773066, 32'sd5200282, -32'sd1528955
  };
  localparam logic [TOL_W-1:0] TOL_RST = 31'd66;

  // Status of one polynomial evaluation.
  typedef struct packed {
    logic done;
    logic zero;
    logic neg;
  } sign_t;

endpackage

`default_nettype wire

>>> rtl/bpr_cfg.sv
// APB-style register file: six polynomial coefficients and the stop tolerance.
// Depends on bpr_pkg.
`default_nettype none

module bpr_cfg
  import bpr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output coef_arr_t              coef_o,
  output logic      [TOL_W-1:0]  tol_o
);

  coef_arr_t        coef_q;
  logic [TOL_W-1:0] tol_q;
  logic [2:0]       idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RST;
      tol_q  <= TOL_RST;
    end else if (wr_en) begin
      if (idx == REG_TOL) begin
        tol_q <= pwdata[TOL_W-1:0];
      end else if (idx <= REG_COEF_LAST) begin
        coef_q[idx] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_TOL) begin
      prdata = {1'b0, tol_q};
    end else if (idx <= REG_COEF_LAST) begin
      prdata = coef_q[idx];
    end
  end

  assign coef_o = coef_q;
  assign tol_o  = tol_q;

endmodule

`default_nettype wire

>>> rtl/bpr_horner.sv
// Horner evaluation of the degree-five polynomial on one shared 32x32 multiplier.
// Returns only a done flag and the sign and zero flag of the saturated result. Depends on bpr_pkg.
`default_nettype none

module bpr_horner
  import bpr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic signed [31:0] x_i,
  input  wire coef_arr_t        coef_i,
  output sign_t                 res_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL0 = 3'd1;
  localparam logic [2:0] PH_MUL1 = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_ADD  = 3'd4;
  localparam logic [2:0] PH_ABS  = 3'd5;

  localparam int unsigned FULL_W = MAG_W + 33;

  logic [2:0]           phase_q, phase_d;
  logic [2:0]           k_q, k_d;
  logic [31:0]          mx_q;
  logic                 xneg_q;
  logic [MAG_W-1:0]     ma_q, ma_d;
  logic                 aneg_q, aneg_d;
  logic [63:0]          p0_q;
  logic [MAG_W-1:0]     p1_q;
  logic [MAG_W-1:0]     q_q, q_d;
  logic                 qneg_q;
  logic signed [48:0]   s_q, s_d;

  logic [32:0]          x_ext, x_abs, c5_ext, c5_abs;
  logic [31:0]          mul_a;
  logic [63:0]          mul_p;
  logic [FULL_W-1:0]    full, full_sh;
  logic signed [48:0]   coef_ext;
  logic [48:0]          q_ext;
  logic [48:0]          s_abs;

  assign x_ext  = {x_i[31], x_i};
  assign x_abs  = x_i[31] ? (~x_ext + 33'd1) : x_ext;
  assign c5_ext = {coef_i[NUM_COEF-1][31], coef_i[NUM_COEF-1]};
  assign c5_abs = c5_ext[32] ? (~c5_ext + 33'd1) : c5_ext;

  // The accumulator magnitude is multiplied in two pieces: low 32 bits, then the rest.
  assign mul_a = (phase_q == PH_MUL0) ? ma_q[31:0] : {17'b0, ma_q[MAG_W-1:32]};
  assign mul_p = 64'(mul_a) * 64'(mx_q);

  assign full    = {16'b0, p0_q} + {1'b0, p1_q, 32'b0};
  assign full_sh = full >> FRAC_BITS;

  assign coef_ext = {{17{coef_i[k_q][31]}}, coef_i[k_q]};
  assign q_ext    = {2'b0, q_q};
  assign s_abs    = s_q[48] ? 49'(-s_q) : 49'(s_q);

  always_comb begin
    phase_d = phase_q;
    k_d     = k_q;
    ma_d    = ma_q;
    aneg_d  = aneg_q;
    q_d     = q_q;
    s_d     = s_q;
    unique case (phase_q)
      PH_MUL0: phase_d = PH_MUL1;
      PH_MUL1: phase_d = PH_SUM;
      PH_SUM: begin
        q_d     = (full_sh > {{(FULL_W-MAG_W){1'b0}}, ACC_LIMIT}) ? ACC_LIMIT
                                                                   : full_sh[MAG_W-1:0];
        phase_d = PH_ADD;
      end
      PH_ADD: begin
        s_d     = qneg_q ? (coef_ext - $signed(q_ext)) : (coef_ext + $signed(q_ext));
        phase_d = PH_ABS;
      end
      PH_ABS: begin
        // Clamping to the symmetric limit keeps the sign, so only the magnitude saturates.
        ma_d   = (s_abs[48:MAG_W] != '0) ? ACC_LIMIT : s_abs[MAG_W-1:0];
        aneg_d = s_q[48];
        if (k_q == '0) begin
          phase_d = PH_IDLE;
        end else begin
          k_d     = k_q - 3'd1;
          phase_d = PH_MUL0;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    if (start_i) begin
      ma_d    = {{(MAG_W-33){1'b0}}, c5_abs};
      aneg_d  = c5_ext[32];
      k_d     = 3'(NUM_COEF - 2);
      phase_d = PH_MUL0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    ma_q   <= ma_d;
    aneg_q <= aneg_d;
    q_q    <= q_d;
    s_q    <= s_d;
    if (start_i) begin
      mx_q   <= x_abs[31:0];
      xneg_q <= x_i[31];
    end
    if (phase_q == PH_MUL0) begin
      p0_q <= mul_p;
    end
    if (phase_q == PH_MUL1) begin
      p1_q <= mul_p[MAG_W-1:0];
    end
    if (phase_q == PH_SUM) begin
      qneg_q <= aneg_q ^ xneg_q;
    end
  end

  assign res_o.done = (phase_q == PH_ABS) && (k_q == '0);
  assign res_o.zero = (s_q == '0);
  assign res_o.neg  = s_q[48];

endmodule

`default_nettype wire

>>> rtl/bisection_polynomial_root.sv
// Top level of the bisection root finder: step sequencer, output register,
// configuration registers (bpr_cfg) and the shared Horner unit (bpr_horner).
// Depends on bpr_pkg, bpr_cfg and bpr_horner.
//
//   Channel  Signals                                     Direction  Handshake
//   input    lower_end_i, upper_end_i                    in         in_valid_i / in_stall_o
//   result   root_o, outcome_o, steps_used_o             out        out_valid_o / out_stall_i
//   config   psel, penable, pwrite, paddr, pwdata, ...   in         APB, pready always high
//
// One polynomial evaluation runs five Horner steps, each through the MUL0, MUL1, SUM, ADD
// and ABS phases on the single 32x32 multiplier. An item evaluates both ends of the interval,
// then the midpoint once per bisection step, then loads the result and returns to idle;
// in_stall_o is high until then, so a new input beat waits for the item to end.
// Reset clears the sequencer and output valid and loads the register reset values.
// A result held by out_stall_i does not block the next input beat; the block only waits
// at the end of the following item if the earlier result is still not taken.
`default_nettype none

module bisection_polynomial_root
  import bpr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic signed [31:0]  lower_end_i,
  input  wire logic signed [31:0]  upper_end_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       root_o,
  output logic        [1:0]        outcome_o,
  output logic        [STEP_W-1:0] steps_used_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic   [ADDR_W-1:0] paddr,
  input  wire logic   [31:0]       pwdata,
  output logic        [31:0]       prdata,
  output logic                     pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STA  = 3'd1;
  localparam logic [2:0] S_EVA  = 3'd2;
  localparam logic [2:0] S_EVB  = 3'd3;
  localparam logic [2:0] S_MID  = 3'd4;
  localparam logic [2:0] S_DIF  = 3'd5;
  localparam logic [2:0] S_EVC  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  coef_arr_t          coef;
  logic [TOL_W-1:0]   tol;
  sign_t              ev;
  logic               ev_start;
  logic signed [31:0] ev_x;

  logic [2:0]         state_q, state_d;
  logic signed [31:0] a_q, b_q, c_q, prevc_q;
  logic               sa_zero_q, sa_neg_q, sb_zero_q, sb_neg_q;
  logic [STEP_W-1:0]  step_q;
  logic               near_q;
  logic [1:0]         res_q;

  logic               out_valid_q;
  logic signed [31:0] root_q;
  logic [1:0]         outcome_q;
  logic [STEP_W-1:0]  steps_q;

  logic               in_acc, out_load;
  logic signed [32:0] mid_sum, diff;
  logic [32:0]        diff_abs;
  logic               cross_a, cross_b;

  bpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .tol_o   (tol)
  );

  bpr_horner u_horner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ev_start),
    .x_i     (ev_x),
    .coef_i  (coef),
    .res_o   (ev)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign ev_start = (state_q == S_STA) || (state_q == S_DIF) ||
                    ((state_q == S_EVA) && ev.done);
  always_comb begin
    unique case (state_q)
      S_STA:   ev_x = a_q;
      S_EVA:   ev_x = b_q;
      default: ev_x = c_q;
    endcase
  end

  // Floor of the mean: the 33-bit sum shifted arithmetically.
  assign mid_sum  = {a_q[31], a_q} + {b_q[31], b_q};
  assign diff     = {c_q[31], c_q} - {prevc_q[31], prevc_q};
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

  // A sign change needs two nonzero values of opposite sign.
  assign cross_a = !sa_zero_q && !ev.zero && (sa_neg_q != ev.neg);
  assign cross_b = !sb_zero_q && !ev.zero && (sb_neg_q != ev.neg);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_STA;
      S_STA:  state_d = S_EVA;
      S_EVA:  if (ev.done) state_d = S_EVB;
      S_EVB:  if (ev.done) state_d = S_MID;
      S_MID:  state_d = S_DIF;
      S_DIF:  state_d = S_EVC;
      S_EVC: begin
        if (ev.done) begin
          if (ev.zero || (!cross_a && !cross_b) || near_q ||
              (step_q == STEP_W'(MAX_STEPS))) begin
            state_d = S_FIN;
          end else begin
            state_d = S_MID;
          end
        end
      end
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q    <= lower_end_i;
      b_q    <= upper_end_i;
      step_q <= '0;
    end
    if ((state_q == S_EVA) && ev.done) begin
      sa_zero_q <= ev.zero;
      sa_neg_q  <= ev.neg;
    end
    if ((state_q == S_EVB) && ev.done) begin
      sb_zero_q <= ev.zero;
      sb_neg_q  <= ev.neg;
    end
    if (state_q == S_MID) begin
      c_q     <= mid_sum[32:1];
      prevc_q <= c_q;
      step_q  <= step_q + STEP_W'(1);
    end
    if (state_q == S_DIF) begin
      // The first step has no earlier midpoint to compare against.
      near_q <= (step_q != STEP_W'(1)) && (diff_abs < {2'b0, tol});
    end
    if ((state_q == S_EVC) && ev.done) begin
      if (ev.zero) begin
        res_q <= OUT_CONV;
      end else if (cross_a) begin
        b_q       <= c_q;
        sb_zero_q <= ev.zero;
        sb_neg_q  <= ev.neg;
        res_q     <= near_q ? OUT_CONV : OUT_LIMIT;
      end else if (cross_b) begin
        a_q       <= c_q;
        sa_zero_q <= ev.zero;
        sa_neg_q  <= ev.neg;
        res_q     <= near_q ? OUT_CONV : OUT_LIMIT;
      end else begin
        res_q <= OUT_NOSIGN;
      end
    end
    if (out_load) begin
      root_q    <= c_q;
      outcome_q <= res_q;
      steps_q   <= step_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign outcome_o    = outcome_q;
  assign steps_used_o = steps_q;

  // The evaluation unit reports only while the sequencer is waiting for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.done |-> (state_q == S_EVA || state_q == S_EVB || state_q == S_EVC))
    else $error("evaluation finished outside a wait state");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OUT_CONV || outcome_o == OUT_NOSIGN ||
                     outcome_o == OUT_LIMIT))
    else $error("result carries an unknown outcome code");

  a_steps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (steps_used_o != '0) && (steps_used_o <= STEP_W'(MAX_STEPS)))
    else $error("step count out of range");

  a_limit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUT_LIMIT) |-> (steps_used_o == STEP_W'(MAX_STEPS)))
    else $error("step limit reported before the last step");

endmodule

`default_nettype wire
